@@ hdl/brf_pkg.sv @@
// Shared types, codes and saturating helpers for the Brent root finder.
// Depends on nothing; used by brent_root_finder_core.
`timescale 1ns / 1ps

package brf_pkg;

    // Command codes of the input transaction
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_EVAL    = 2'd0;
    localparam logic [1:0] KIND_ROOT    = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_TOLERANCE  = 2'd0;
    localparam logic [1:0] REG_REL_EPS    = 2'd1;
    localparam logic [1:0] REG_ITER_LIMIT = 2'd2;

    // relative_eps is Q0.16 regardless of the data format
    localparam int EPS_FRAC = 16;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               command;
        logic signed [31:0] bracket_low;
        logic signed [31:0] bracket_high;
        logic signed [31:0] func_value;
    } brf_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] point;
    } brf_result_t;

    function automatic logic signed [33:0] ext34(input logic signed [31:0] x);
        return {{2{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = S32_MAX;
        else if (v < -34'sd2147483648)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] fadd32(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
        return sat34(ext34(x) + ext34(y));
    endfunction

    function automatic logic signed [31:0] fsub32(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
        return sat34(ext34(x) - ext34(y));
    endfunction

    function automatic logic signed [31:0] dbl32(input logic signed [31:0] x);
        return sat34(ext34(x) <<< 1);
    endfunction

    function automatic logic signed [31:0] tri32(input logic signed [31:0] x);
        return sat34(ext34(x) + (ext34(x) <<< 1));
    endfunction

    function automatic logic signed [31:0] neg32(input logic signed [31:0] x);
        return sat34(-ext34(x));
    endfunction

    // Magnitude as unsigned; the most negative value maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? $unsigned(-x) : $unsigned(x);
    endfunction

    function automatic logic signed [31:0] fabs32(input logic signed [31:0] x);
        return (x == S32_MIN) ? S32_MAX : $signed(mag32(x));
    endfunction

endpackage

@@ hdl/brf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Uses no package; instantiated by brent_root_finder_core.
`timescale 1ns / 1ps

module brf_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

@@ hdl/brent_root_finder_core.sv @@
// Brent root finder top level: bracket handling, Brent iteration sequencer.
// Depends on brf_pkg and brf_div.
`timescale 1ns / 1ps

// Brent root refinement engine in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). The function itself lives outside: a start transaction
// (command 0) gives the bracket and the block answers with bracket_low to
// evaluate; each value transaction (command 1) carries f at the last requested
// point. From the second bracket value on, every value runs one Brent iteration
// (inverse quadratic or secant step, bisection fallback) and the result
// transaction asks for the next point (kind 0), reports the root (kind 1),
// reports failure with bracket_high plus or minus one, away from bracket_low,
// once iteration_limit is used up (kind 2), or flags a value sent while no
// search runs (kind 3, point 0). Sums, products and quotients saturate; a
// divide by zero saturates by the numerator's sign. Timing: one item at a time;
// item_ready is high only while the sequencer is idle. Start, first value and
// ignored values go from idle straight to the output state. An iteration walks
// through one shared multiplier (one product per cycle) and one restoring
// divider that loads and then takes one step per quotient bit (32+FRAC_BITS
// bits, 48 at Q16.16), up to four divides. A bisection step runs S_CHK to
// S_CONV, then S_STEP; a root report leaves from S_CONV, a limit failure from
// S_CHK. The result sits in an output register, so the next item is taken while
// the previous result still waits. Configuration writes are taken every cycle.

module brent_root_finder_core
    import brf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  brf_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output brf_result_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NW = 32 + FRAC_BITS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] MUL_BIAS = (66'sd1 <<< FRAC_BITS) - 66'sd1;
    localparam logic [NW-1:0] QPOS_MAX = {{(NW-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic [NW-1:0] QNEG_MAX = {{(NW-32){1'b0}}, 32'h8000_0000};

    // Search phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_WAIT_A = 4'b0010,
        PH_WAIT_B = 4'b0100,
        PH_ITER   = 4'b1000
    } phase_t;

    // Iteration sequencer
    typedef enum logic [22:0] {
        S_IDLE = 23'h000001,
        S_CHK  = 23'h000002,
        S_SWAP = 23'h000004,
        S_TOL  = 23'h000008,
        S_CONV = 23'h000010,
        S_DS   = 23'h000020,
        S_DQ   = 23'h000040,
        S_DR   = 23'h000080,
        S_P1   = 23'h000100,
        S_M1   = 23'h000200,
        S_M2   = 23'h000400,
        S_M3   = 23'h000800,
        S_M4   = 23'h001000,
        S_M5   = 23'h002000,
        S_M6   = 23'h004000,
        S_SIGN = 23'h008000,
        S_M7   = 23'h010000,
        S_M8   = 23'h020000,
        S_M9   = 23'h040000,
        S_DEC  = 23'h080000,
        S_DD   = 23'h100000,
        S_STEP = 23'h200000,
        S_OUT  = 23'h400000
    } seq_t;

    seq_t   state_reg, state_next;
    phase_t phase_reg, phase_next;

    // Configuration
    logic [30:0] tol_reg, tol_next;
    logic [15:0] eps_reg, eps_next;
    logic [15:0] lim_reg, lim_next;

    // Brent state
    logic signed [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic signed [31:0] fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic signed [31:0] d_reg, d_next, e_reg, e_next, upper_reg, upper_next;
    logic               asc_reg, asc_next;
    logic [15:0]        cnt_reg, cnt_next;

    // Per-iteration scratch
    logic signed [31:0] tol1_reg, tol1_next, xm_reg, xm_next;
    logic signed [31:0] s_reg, s_next, q_reg, q_next, r_reg, r_next;
    logic signed [31:0] p_reg, p_next, t1_reg, t1_next, t2_reg, t2_next;

    // Pending and registered result
    logic [1:0]         rk_reg, rk_next;
    logic signed [31:0] rp_reg, rp_next;
    logic               out_valid_reg, out_valid_next;
    brf_result_t        out_reg, out_next;

    // Shared multiplier
    logic signed [32:0] mul_x, mul_y;
    logic signed [65:0] mul_prod, mul_adj, mul_shf;
    logic signed [31:0] mul_res;

    // Shared divider
    logic               div_start;
    logic signed [31:0] div_x, div_y;
    logic               div_done;
    logic [NW-1:0]      div_q;
    logic               dneg_reg, dneg_next, dzero_reg, dzero_next, dxneg_reg, dxneg_next;
    logic signed [31:0] div_res;

    // Combinational helpers
    logic signed [32:0] cb_diff;
    logic signed [32:0] cb_half;
    logic signed [31:0] min2, min_sel, step_b;

    brf_div #(
        .NW (NW),
        .DW (32)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({mag32(div_x), {FRAC_BITS{1'b0}}}),
        .den   (mag32(div_y)),
        .done  (div_done),
        .quot  (div_q)
    );

    // Multiplier operand select per step
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            S_TOL:
            begin
                mul_x = {16'd0, eps_reg, 1'b0};
                mul_y = {1'b0, mag32(b_reg)};
            end
            S_P1:
            begin
                mul_x = 33'(dbl32(xm_reg));
                mul_y = 33'(s_reg);
            end
            S_M1:
            begin
                mul_x = 33'(dbl32(xm_reg));
                mul_y = 33'(q_reg);
            end
            S_M2:
            begin
                mul_x = 33'(t1_reg);
                mul_y = 33'(fsub32(q_reg, r_reg));
            end
            S_M3:
            begin
                mul_x = 33'(fsub32(b_reg, a_reg));
                mul_y = 33'(fsub32(r_reg, ONE));
            end
            S_M4:
            begin
                mul_x = 33'(s_reg);
                mul_y = 33'(fsub32(t1_reg, t2_reg));
            end
            S_M5:
            begin
                mul_x = 33'(fsub32(q_reg, ONE));
                mul_y = 33'(fsub32(r_reg, ONE));
            end
            S_M6:
            begin
                mul_x = 33'(t1_reg);
                mul_y = 33'(fsub32(s_reg, ONE));
            end
            S_M7:
            begin
                mul_x = 33'(tri32(xm_reg));
                mul_y = 33'(q_reg);
            end
            S_M8:
            begin
                mul_x = 33'(tol1_reg);
                mul_y = 33'(q_reg);
            end
            S_M9:
            begin
                mul_x = 33'(e_reg);
                mul_y = 33'(q_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // Product scaled back with truncation toward zero, or tol1 in S_TOL
    assign mul_prod = 66'(mul_x) * 66'(mul_y);
    assign mul_adj  = (state_reg == S_TOL) ? ((mul_prod >>> EPS_FRAC) + $signed({36'd0, tol_reg[30:1]}))
                    : (mul_prod + (mul_prod[65] ? MUL_BIAS : 66'sd0));
    assign mul_shf  = (state_reg == S_TOL) ? mul_adj : (mul_adj >>> FRAC_BITS);
    assign mul_res  = (mul_shf > 66'sd2147483647) ? S32_MAX
                    : ((mul_shf < -66'sd2147483648) ? S32_MIN : mul_shf[31:0]);

    // Quotient sign and saturation
    always_comb
    begin
        if (dzero_reg)
            div_res = dxneg_reg ? S32_MIN : S32_MAX;
        else if (!dneg_reg)
            div_res = (div_q > QPOS_MAX) ? S32_MAX : $signed(div_q[31:0]);
        else
            div_res = (div_q > QNEG_MAX) ? S32_MIN : -$signed(div_q[31:0]);
    end

    // xm = (c - b) / 2, truncated toward zero
    assign cb_diff = {c_reg[31], c_reg} - {b_reg[31], b_reg};
    assign cb_half = (cb_diff + {32'd0, cb_diff[32]}) >>> 1;

    assign min2    = fabs32(t2_reg);
    assign min_sel = (t1_reg < min2) ? t1_reg : min2;
    assign step_b  = (mag32(d_reg) > $unsigned(tol1_reg)) ? fadd32(b_reg, d_reg)
                   : fadd32(b_reg, (xm_reg > 0) ? tol1_reg : -tol1_reg);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        tol_next       = tol_reg;
        eps_next       = eps_reg;
        lim_next       = lim_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        fc_next        = fc_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        upper_next     = upper_reg;
        asc_next       = asc_reg;
        cnt_next       = cnt_reg;
        tol1_next      = tol1_reg;
        xm_next        = xm_reg;
        s_next         = s_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        rk_next        = rk_reg;
        rp_next        = rp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        dneg_next      = dneg_reg;
        dzero_next     = dzero_reg;
        dxneg_next     = dxneg_reg;
        div_start      = 1'b0;
        div_x          = '0;
        div_y          = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOLERANCE:  tol_next = cfg_data[30:0];
                REG_REL_EPS:    eps_next = cfg_data[15:0];
                REG_ITER_LIMIT: lim_next = cfg_data[15:0];
                default:        ;
            endcase
        end

        if (result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    rk_next    = KIND_EVAL;
                    state_next = S_OUT;
                    if (item.command == CMD_START)
                    begin
                        a_next     = item.bracket_low;
                        b_next     = item.bracket_high;
                        c_next     = '0;
                        fa_next    = '0;
                        fb_next    = '0;
                        fc_next    = '0;
                        d_next     = '0;
                        e_next     = '0;
                        upper_next = item.bracket_high;
                        asc_next   = item.bracket_low < item.bracket_high;
                        cnt_next   = '0;
                        phase_next = PH_WAIT_A;
                        rp_next    = item.bracket_low;
                    end
                    else if (phase_reg == PH_IDLE)
                    begin
                        rk_next = KIND_IGNORED;
                        rp_next = '0;
                    end
                    else if (phase_reg == PH_WAIT_A)
                    begin
                        fa_next    = item.func_value;
                        phase_next = PH_WAIT_B;
                        rp_next    = b_reg;
                    end
                    else
                    begin
                        fb_next = item.func_value;
                        if (phase_reg == PH_WAIT_B)
                            fc_next = item.func_value;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (cnt_reg >= lim_reg)
                begin
                    rk_next    = KIND_FAIL;
                    rp_next    = fadd32(upper_reg, asc_reg ? ONE : -ONE);
                    phase_next = PH_IDLE;
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 16'd1;
                    if ((fb_reg > 0 && fc_reg > 0) || (fb_reg < 0 && fc_reg < 0))
                    begin
                        c_next  = a_reg;
                        fc_next = fa_reg;
                        d_next  = fsub32(b_reg, a_reg);
                        e_next  = fsub32(b_reg, a_reg);
                    end
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                // keep b as the best estimate
                if (mag32(fc_reg) < mag32(fb_reg))
                begin
                    a_next  = b_reg;
                    b_next  = c_reg;
                    c_next  = b_reg;
                    fa_next = fb_reg;
                    fb_next = fc_reg;
                    fc_next = fb_reg;
                end
                state_next = S_TOL;
            end
            S_TOL:
            begin
                tol1_next  = mul_res;
                xm_next    = cb_half[31:0];
                state_next = S_CONV;
            end
            S_CONV:
            begin
                if (mag32(xm_reg) <= $unsigned(tol1_reg) || fb_reg == 0)
                begin
                    rk_next    = KIND_ROOT;
                    rp_next    = b_reg;
                    phase_next = PH_IDLE;
                    state_next = S_OUT;
                end
                else if (mag32(e_reg) >= $unsigned(tol1_reg) && mag32(fa_reg) > mag32(fb_reg))
                begin
                    div_start  = 1'b1;
                    div_x      = fb_reg;
                    div_y      = fa_reg;
                    state_next = S_DS;
                end
                else
                begin
                    d_next     = xm_reg;
                    e_next     = xm_reg;
                    state_next = S_STEP;
                end
            end
            S_DS:
            begin
                if (div_done)
                begin
                    s_next = div_res;
                    if (a_reg == c_reg)
                        state_next = S_P1;
                    else
                    begin
                        div_start  = 1'b1;
                        div_x      = fa_reg;
                        div_y      = fc_reg;
                        state_next = S_DQ;
                    end
                end
            end
            S_DQ:
            begin
                if (div_done)
                begin
                    q_next     = div_res;
                    div_start  = 1'b1;
                    div_x      = fb_reg;
                    div_y      = fc_reg;
                    state_next = S_DR;
                end
            end
            S_DR:
            begin
                if (div_done)
                begin
                    r_next     = div_res;
                    state_next = S_M1;
                end
            end
            S_P1:
            begin
                // secant step
                p_next     = mul_res;
                q_next     = fsub32(ONE, s_reg);
                state_next = S_SIGN;
            end
            S_M1:
            begin
                t1_next    = mul_res;
                state_next = S_M2;
            end
            S_M2:
            begin
                t1_next    = mul_res;
                state_next = S_M3;
            end
            S_M3:
            begin
                t2_next    = mul_res;
                state_next = S_M4;
            end
            S_M4:
            begin
                p_next     = mul_res;
                state_next = S_M5;
            end
            S_M5:
            begin
                t1_next    = mul_res;
                state_next = S_M6;
            end
            S_M6:
            begin
                q_next     = mul_res;
                state_next = S_SIGN;
            end
            S_SIGN:
            begin
                if (p_reg > 0)
                    q_next = neg32(q_reg);
                p_next     = fabs32(p_reg);
                state_next = S_M7;
            end
            S_M7:
            begin
                t1_next    = mul_res;
                state_next = S_M8;
            end
            S_M8:
            begin
                t2_next    = mul_res;
                state_next = S_M9;
            end
            S_M9:
            begin
                t1_next    = fsub32(t1_reg, fabs32(t2_reg));
                t2_next    = mul_res;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                // accept interpolation only if it stays well inside the bracket
                if (dbl32(p_reg) < min_sel)
                begin
                    e_next     = d_reg;
                    div_start  = 1'b1;
                    div_x      = p_reg;
                    div_y      = q_reg;
                    state_next = S_DD;
                end
                else
                begin
                    d_next     = xm_reg;
                    e_next     = xm_reg;
                    state_next = S_STEP;
                end
            end
            S_DD:
            begin
                if (div_done)
                begin
                    d_next     = div_res;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                a_next     = b_reg;
                fa_next    = fb_reg;
                b_next     = step_b;
                rk_next    = KIND_EVAL;
                rp_next    = step_b;
                phase_next = PH_ITER;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.kind  = rk_reg;
                    out_next.point = rp_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (div_start)
        begin
            dzero_next = (div_y == 0);
            dxneg_next = div_x[31];
            dneg_next  = div_x[31] ^ div_y[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            tol_reg       <= 31'd66;
            eps_reg       <= 16'd0;
            lim_reg       <= 16'd100;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            fa_reg        <= '0;
            fb_reg        <= '0;
            fc_reg        <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            upper_reg     <= '0;
            asc_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tol_reg       <= tol_next;
            eps_reg       <= eps_next;
            lim_reg       <= lim_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            fa_reg        <= fa_next;
            fb_reg        <= fb_next;
            fc_reg        <= fc_next;
            d_reg         <= d_next;
            e_reg         <= e_next;
            upper_reg     <= upper_next;
            asc_reg       <= asc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scratch and payload, no reset needed
    always_ff @(posedge clk)
    begin
        tol1_reg  <= tol1_next;
        xm_reg    <= xm_next;
        s_reg     <= s_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        p_reg     <= p_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        rk_reg    <= rk_next;
        rp_reg    <= rp_next;
        out_reg   <= out_next;
        dneg_reg  <= dneg_next;
        dzero_reg <= dzero_next;
        dxneg_reg <= dxneg_next;
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

endmodule

@@ tb/brent_root_finder_core_tb.sv @@
// Self-checking testbench for brent_root_finder_core: directed and random Brent searches.
// Depends on brf_pkg and the RTL of brent_root_finder_core, which in turn needs brf_div.
`timescale 1ns / 1ps

module brent_root_finder_core_tb;
    import brf_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 400;

    // Search phases of the predictor
    typedef enum logic [1:0] {SRCH_IDLE, SRCH_WAIT_LO, SRCH_WAIT_HI, SRCH_ITER} srch_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    brf_item_t   item;
    logic        result_valid;
    logic        result_ready;
    brf_result_t result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    brent_root_finder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor state: configuration copy and search registers
    longint tol_q, eps_q, limit_q;
    srch_t  srch;
    longint pa, pb, pc, fa_s, fb_s, fc_s, step_d, step_e, hi_end;
    longint iter_cnt;
    bit     rising;

    brf_result_t expected_results[$];
    int     fail_count;
    int     cycle_count;
    int     item_count;     // input transactions accepted so far
    bit     idle_gaps;      // random idling of the sender and receiver

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint sat(input longint v);
        return v > MAXV ? MAXV : (v < MINV ? MINV : v);
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint qmul(input longint x, input longint y);
        return sat((x * y) / ONE);
    endfunction

    function automatic longint qdiv(input longint x, input longint y);
        if (y == 0)
            return x < 0 ? MINV : MAXV;
        return sat((x * ONE) / y);
    endfunction

    // One Brent iteration on the stored search; returns kind, point via output arguments
    task automatic brent_iterate(output logic [1:0] kind, output longint pt);
        longint a, b, c, fa, fb, fc, d, e, tol1, xm, s, p, q, r, min1, min2;
        a = pa; b = pb; c = pc; fa = fa_s; fb = fb_s; fc = fc_s;
        d = step_d; e = step_e;
        if (iter_cnt >= limit_q)
        begin
            pt = sat(rising ? hi_end + ONE : hi_end - ONE);
            srch = SRCH_IDLE;
            kind = KIND_FAIL;
            return;
        end
        iter_cnt++;
        if ((fb > 0 && fc > 0) || (fb < 0 && fc < 0))
        begin
            c = a; fc = fa; d = sat(b - a); e = d;
        end
        if (mag(fc) < mag(fb))
        begin
            a = b; b = c; c = a;
            fa = fb; fb = fc; fc = fa;
        end
        tol1 = sat(((2 * eps_q * mag(b)) >>> 16) + (tol_q >>> 1));
        xm = (c - b) / 2;
        if (mag(xm) <= tol1 || fb == 0)
        begin
            pt = b;
            srch = SRCH_IDLE;
            kind = KIND_ROOT;
            return;
        end
        if (mag(e) >= tol1 && mag(fa) > mag(fb))
        begin
            s = qdiv(fb, fa);
            if (a == c)
            begin
                p = qmul(sat(2 * xm), s);
                q = sat(ONE - s);
            end
            else
            begin
                q = qdiv(fa, fc);
                r = qdiv(fb, fc);
                p = qmul(s, sat(qmul(qmul(sat(2 * xm), q), sat(q - r))
                                - qmul(sat(b - a), sat(r - ONE))));
                q = qmul(qmul(sat(q - ONE), sat(r - ONE)), sat(s - ONE));
            end
            if (p > 0)
                q = sat(-q);
            p = sat(mag(p));
            min1 = sat(qmul(sat(3 * xm), q) - sat(mag(qmul(tol1, q))));
            min2 = sat(mag(qmul(e, q)));
            if (sat(2 * p) < (min1 < min2 ? min1 : min2))
            begin
                e = d;
                d = qdiv(p, q);
            end
            else
            begin
                d = xm; e = d;
            end
        end
        else
        begin
            d = xm; e = d;
        end
        a = b; fa = fb;
        if (mag(d) > tol1)
            b = sat(b + d);
        else
            b = sat(b + (xm > 0 ? tol1 : -tol1));
        pa = a; pb = b; pc = c; fa_s = fa; fb_s = fb; fc_s = fc;
        step_d = d; step_e = e;
        srch = SRCH_ITER;
        pt = b;
        kind = KIND_EVAL;
    endtask

    // Predicts the result of one accepted input transaction
    task automatic predict_search(input brf_item_t it);
        brf_result_t res;
        longint pt;
        logic [1:0] kind;
        pt = 0;
        kind = KIND_EVAL;
        if (it.command == CMD_START)
        begin
            pa = it.bracket_low; pb = it.bracket_high; pc = 0;
            fa_s = 0; fb_s = 0; fc_s = 0; step_d = 0; step_e = 0;
            hi_end = it.bracket_high;
            rising = it.bracket_low < it.bracket_high;
            iter_cnt = 0;
            srch = SRCH_WAIT_LO;
            pt = it.bracket_low;
        end
        else if (srch == SRCH_IDLE)
            kind = KIND_IGNORED;
        else if (srch == SRCH_WAIT_LO)
        begin
            fa_s = it.func_value;
            srch = SRCH_WAIT_HI;
            pt = pb;
        end
        else
        begin
            fb_s = it.func_value;
            if (srch == SRCH_WAIT_HI)
                fc_s = it.func_value;
            brent_iterate(kind, pt);
        end
        res.kind = kind;
        res.point = pt[31:0];
        expected_results.push_back(res);
    endtask

    // Sends one transaction and holds it until accepted; valid stays high
    // afterwards until the next transaction, an idle gap or wait_drained replaces it
    task automatic send_item(input logic cmd, input logic signed [31:0] lo,
                             input logic signed [31:0] hi, input logic signed [31:0] fv);
        while (idle_gaps && $urandom_range(99) < 36)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item.command <= cmd;
        item.bracket_low <= lo;
        item.bracket_high <= hi;
        item.func_value <= fv;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        item_count++;
        predict_search('{command: cmd, bracket_low: lo, bracket_high: hi, func_value: fv});
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with nothing in flight
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TOLERANCE:  tol_q = val[30:0];
            REG_REL_EPS:    eps_q = val[15:0];
            REG_ITER_LIMIT: limit_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] tol, input logic [31:0] eps,
                              input logic [31:0] lim);
        wait_drained();
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_REL_EPS, eps);
        write_reg(REG_ITER_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    // f(x) of one of four synthetic curves around root: linear, signed-square, cubic-like
    function automatic logic signed [31:0] curve_value(input longint x, input longint root,
                                                       input int shape);
        longint dx, v;
        dx = x - root;
        case (shape)
            0: v = sat(dx);
            1: v = sat(qmul(dx, mag(dx)) + dx / 4);
            2: v = sat(-3 * dx);
            default: v = sat(qmul(qmul(dx, dx), dx) + dx);
        endcase
        return v[31:0];
    endfunction

    // One search against a synthetic function, run until it ends or max_vals values are sent
    task automatic run_search(input longint lo, input longint hi, input int max_vals);
        longint root, x;
        int shape, n;
        root = lo + (hi - lo) * longint'($urandom_range(1000)) / 1000;
        shape = $urandom_range(3);
        send_item(CMD_START, lo[31:0], hi[31:0], $urandom);
        x = lo;
        for (n = 0; n < max_vals && srch != SRCH_IDLE; n++)
        begin
            send_item(CMD_VALUE, $urandom, $urandom, curve_value(x, root, shape));
            x = $signed(expected_results[$].point);
        end
    endtask

    task automatic test_directed();
        // ignored value while idle, extremes of every field
        send_item(CMD_VALUE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(CMD_VALUE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        // full-range bracket with extreme values, restart while busy
        send_item(CMD_START, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_item(CMD_VALUE, 0, 0, 32'sh8000_0000);
        send_item(CMD_START, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_item(CMD_VALUE, 0, 0, 32'sh7FFF_FFFF);
        send_item(CMD_VALUE, 0, 0, 32'sh8000_0000);
        send_item(CMD_VALUE, 0, 0, 0);
        // unbracketed start: both values positive
        send_item(CMD_START, -32'sd65536, 32'sd65536, 0);
        send_item(CMD_VALUE, 0, 0, 32'sd100);
        send_item(CMD_VALUE, 0, 0, 32'sd200);
        send_item(CMD_VALUE, 0, 0, 32'sd50);
        // zero value at the bracket end gives a root at once
        send_item(CMD_START, 32'sd0, 32'sd131072, 0);
        send_item(CMD_VALUE, 0, 0, -32'sd5);
        send_item(CMD_VALUE, 0, 0, 32'sd0);
        // zero value at a, nonzero at b: the swap reports a as the root at once
        send_item(CMD_START, 32'sd65536, 32'sd196608, 0);
        send_item(CMD_VALUE, 0, 0, 32'sd0);
        send_item(CMD_VALUE, 0, 0, 32'sd70000);
        send_item(CMD_VALUE, 0, 0, 32'sd1);
    endtask

    task automatic test_iteration_limit();
        set_config(32'd0, 32'd0, 32'd1);
        run_search(-64'sd300000, 64'sd500000, 8);
        run_search(64'sd400000, -64'sd900000, 8);
        // limit zero fails on the second bracket value
        set_config(32'd0, 32'd0, 32'd0);
        run_search(64'sd2147483000, -64'sd1000, 4);
        run_search(-64'sd2147483000, 64'sd1000, 4);
    endtask

    task automatic test_random_searches(input int budget);
        int sent, first;
        longint lo, hi;
        first = item_count;
        sent = 0;
        while (sent < budget)
        begin
            if (sent > budget / 3 && sent < budget / 2)
                idle_gaps = 1'b0;
            else
                idle_gaps = 1'b1;
            if ($urandom_range(9) == 0)
                send_item(1'($urandom_range(1)), $urandom, $urandom, $urandom);
            else
            begin
                if ($urandom_range(4) == 0)
                begin
                    lo = $signed(32'($urandom));
                    hi = $signed(32'($urandom));
                end
                else
                begin
                    lo = $signed(32'($urandom_range(8000000))) - 4000000;
                    hi = lo + $urandom_range(4000000) + 1;
                    if ($urandom_range(1))
                    begin
                        lo = hi;
                        hi = hi - $urandom_range(4000000) - 1;
                    end
                end
                run_search(lo, hi, $urandom_range(3) == 0 ? $urandom_range(3) : 40);
            end
            sent = item_count - first;
        end
        idle_gaps = 1'b1;
    endtask

    // Result receiver with random stalls and field checks
    initial
    begin
        brf_result_t exp_res;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d point=%0d", $time,
                             result.kind, result.point);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result.kind !== exp_res.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time,
                                 exp_res.kind, result.kind);
                        fail_count++;
                    end
                    if (result.point !== exp_res.point)
                    begin
                        $display("%0t: point expected %0d actual %0d", $time,
                                 exp_res.point, result.point);
                        fail_count++;
                    end
                end
            end
            result_ready <= !(idle_gaps && $urandom_range(99) < 36);
        end
    end

    // Watchdog on the total run length
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count = 0;
        item_count = 0;
        idle_gaps = 1'b1;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TOLERANCE;
        cfg_data = '0;
        tol_q = 66; eps_q = 0; limit_q = 100;
        srch = SRCH_IDLE;
        pa = 0; pb = 0; pc = 0; fa_s = 0; fb_s = 0; fc_s = 0;
        step_d = 0; step_e = 0; hi_end = 0; iter_cnt = 0; rising = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // sender holds off until all results have come back
        wait_drained();
        test_iteration_limit();
        set_config(32'd66, 32'd0, 32'd100);
        test_random_searches(450);
        set_config(32'h7FFF_FFFF, 32'd65535, 32'd65535);
        test_random_searches(100);
        set_config(32'd1, 32'd655, 32'd30);
        test_random_searches(400);
        set_config(32'd3000, 32'd0, 32'd7);
        test_random_searches(400);
        wait_drained();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
